// File: rtl/dbf_pkg.sv
// Shared types, constants and helper functions for the detection box filter.
package dbf_pkg;

	localparam int NumClasses = 7;
	localparam int NumParams  = 8;
	localparam int ParAw      = $clog2(NumParams);
	localparam int RectDepth  = 4 * NumClasses;
	localparam int RectAw     = $clog2(RectDepth);
	localparam int SetDepth   = NumParams + RectDepth;

	localparam int ParCols     = 0;
	localparam int ParRows     = 1;
	localparam int ParCropX    = 2;
	localparam int ParCropY    = 3;
	localparam int ParWinTop   = 4;
	localparam int ParWinBot   = 5;
	localparam int ParColScale = 6;
	localparam int ParRowScale = 7;

	localparam logic [3:0] LabelRightBelt  = 4'd7;
	localparam logic [3:0] LabelLeftBelt   = 4'd8;
	localparam logic [3:0] LabelRightVisor = 4'd9;
	localparam logic [3:0] LabelLeftVisor  = 4'd10;

	localparam logic [3:0] ClassVisor = 4'd2;
	localparam logic [3:0] ClassBelt  = 4'd4;

	localparam logic ActLoad = 1'b0;
	localparam logic ActBox  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEFT,
		ST_TOP,
		ST_RIGHT,
		ST_BOTTOM,
		ST_CHECK,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic start;
		logic [1:0] edge_sel;
		logic mul;
		logic check;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic keep;
	} status_t;

	function automatic logic [16:0] score_floor(input logic [3:0] cls);
		logic [16:0] r;
		case (cls)
			4'd1: r = 17'd23592;
			4'd2: r = 17'd39321;
			4'd3: r = 17'd39321;
			4'd4: r = 17'd32768;
			4'd5: r = 17'd39321;
			4'd6: r = 17'd39321;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
		logic signed [15:0] r;
		if (v > 36'sd32767)
			r = 16'sh7fff;
		else if (v < -36'sd32768)
			r = -16'sd32768;
		else
			r = v[15:0];
		return r;
	endfunction

	function automatic logic signed [35:0] trunc28(input logic signed [63:0] v);
		logic [63:0] m;
		logic [35:0] q;
		logic signed [35:0] r;
		m = v[63] ? 64'(-v) : 64'(v);
		q = m[63:28];
		r = v[63] ? -$signed(q) : $signed(q);
		return r;
	endfunction

endpackage

// File: rtl/dbf_ctrl.sv
// Sequencer for load items and the per-edge box computation.
module dbf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 action,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  dbf_pkg::status_t     status,
	output dbf_pkg::cmd_t        cmd
);

	dbf_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic in_take;

	assign in_stall  = (state_q != dbf_pkg::ST_IDLE) || (out_valid_q && out_stall);
	assign in_take   = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			dbf_pkg::ST_IDLE:   if (in_take && action == dbf_pkg::ActBox) state_d = dbf_pkg::ST_LEFT;
			dbf_pkg::ST_LEFT:   state_d = dbf_pkg::ST_TOP;
			dbf_pkg::ST_TOP:    state_d = dbf_pkg::ST_RIGHT;
			dbf_pkg::ST_RIGHT:  state_d = dbf_pkg::ST_BOTTOM;
			dbf_pkg::ST_BOTTOM: state_d = dbf_pkg::ST_CHECK;
			dbf_pkg::ST_CHECK:  state_d = dbf_pkg::ST_OUT;
			dbf_pkg::ST_OUT:    if (!(out_valid_q && out_stall)) state_d = dbf_pkg::ST_IDLE;
			default:            state_d = dbf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			dbf_pkg::ST_IDLE: begin
				cmd.load  = in_take && action == dbf_pkg::ActLoad;
				cmd.start = in_take && action == dbf_pkg::ActBox;
			end
			dbf_pkg::ST_LEFT:   begin cmd.mul = 1'b1; cmd.edge_sel = 2'd0; end
			dbf_pkg::ST_TOP:    begin cmd.mul = 1'b1; cmd.edge_sel = 2'd1; end
			dbf_pkg::ST_RIGHT:  begin cmd.mul = 1'b1; cmd.edge_sel = 2'd2; end
			dbf_pkg::ST_BOTTOM: begin cmd.mul = 1'b1; cmd.edge_sel = 2'd3; end
			dbf_pkg::ST_CHECK:  cmd.check = 1'b1;
			dbf_pkg::ST_OUT:    cmd.emit = !(out_valid_q && out_stall) && status.keep;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dbf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/dbf_dp.sv
// Settings store, shared edge multiplier, filter tests and output register.
module dbf_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  dbf_pkg::cmd_t       cmd,
	output dbf_pkg::status_t    status,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [11:0]         split_column,
	input  logic [5:0]          param_index,
	input  logic signed [19:0]  param_value,
	input  logic [3:0]          box_class,
	input  logic [16:0]         box_score,
	input  logic [16:0]         box_left,
	input  logic [16:0]         box_top,
	input  logic [16:0]         box_right,
	input  logic [16:0]         box_bottom,
	output logic signed [15:0]  out_x,
	output logic signed [15:0]  out_y,
	output logic signed [15:0]  out_width,
	output logic signed [15:0]  out_height,
	output logic [3:0]          label,
	output logic [16:0]         confidence
);

	logic [19:0] par_q [dbf_pkg::NumParams];
	logic [19:0] rect_q [dbf_pkg::RectDepth];
	logic signed [36:0] colsc_q, rowsc_q;
	logic [11:0] split_q;
	logic [3:0]  cls_q;
	logic [16:0] score_q;
	logic [16:0] norm_q [4];
	logic        pre_ok_q;
	logic signed [63:0] edge_q [4];
	logic        keep_q;
	logic [3:0]  label_q;
	logic signed [15:0] ox_q, oy_q, ow_q, oh_q;
	logic [16:0] conf_q;

	logic signed [19:0] crop_s;
	logic signed [36:0] mulsc_s;
	logic signed [63:0] edge_s;
	logic [5:0] wr_off;
	logic [5:0] fi0, fi1, fi2, fi3;

	assign cfg_ready = 1'b1;
	assign wr_off    = param_index - 6'(dbf_pkg::NumParams);

	always_comb begin
		if (cmd.edge_sel[0]) begin
			mulsc_s = rowsc_q;
			crop_s  = $signed(par_q[dbf_pkg::ParCropY]);
		end else begin
			mulsc_s = colsc_q;
			crop_s  = $signed(par_q[dbf_pkg::ParCropX]);
		end
		edge_s = 64'($signed({1'b0, norm_q[cmd.edge_sel]}) * mulsc_s) + (64'(crop_s) <<< 24);
	end

	logic signed [63:0] h, lim, top_d, bot_d, xspan;
	logic signed [35:0] rx, ry, rw, rh, fx, fy, fw, fh, x1, y1, x2, y2;
	logic signed [63:0] split_rhs;
	logic ov_c, keep_c, right_c;
	logic [3:0] label_c;

	always_comb begin
		fi0   = {cls_q, 2'b00};
		fi1   = fi0 + 6'd1;
		fi2   = fi0 + 6'd2;
		fi3   = fi0 + 6'd3;
		h     = edge_q[3] - edge_q[1];
		lim   = 3 * h;
		top_d = ((64'($signed(par_q[dbf_pkg::ParWinTop])) <<< 24) - edge_q[1]) * 10;
		bot_d = (edge_q[3] - (64'($signed(par_q[dbf_pkg::ParWinBot])) <<< 24)) * 10;
		xspan = edge_q[2] - edge_q[0];
		rx = dbf_pkg::trunc28(edge_q[0]);
		ry = dbf_pkg::trunc28(edge_q[1]);
		rw = dbf_pkg::trunc28(xspan);
		rh = dbf_pkg::trunc28(h);
		fx = 36'($signed(rect_q[fi0[dbf_pkg::RectAw-1:0]]));
		fy = 36'($signed(rect_q[fi1[dbf_pkg::RectAw-1:0]]));
		fw = 36'($signed(rect_q[fi2[dbf_pkg::RectAw-1:0]]));
		fh = 36'($signed(rect_q[fi3[dbf_pkg::RectAw-1:0]]));
		x1 = rx > fx ? rx : fx;
		y1 = ry > fy ? ry : fy;
		x2 = (rx + rw) < (fx + fw) ? (rx + rw) : (fx + fw);
		y2 = (ry + rh) < (fy + fh) ? (ry + rh) : (fy + fh);
		ov_c = (x2 > x1) && (y2 > y1) && !((x2 - x1 == 36'sd1) && (y2 - y1 == 36'sd1));
		keep_c = pre_ok_q && (h > 0) && !(top_d > lim) && !(bot_d > lim) && !ov_c;
		split_rhs = $signed(64'(split_q) * 64'(par_q[dbf_pkg::ParColScale][15:0])) <<< 16;
		right_c = (edge_q[0] <<< 1) < split_rhs;
		if (cls_q == dbf_pkg::ClassBelt)
			label_c = right_c ? dbf_pkg::LabelRightBelt : dbf_pkg::LabelLeftBelt;
		else if (cls_q == dbf_pkg::ClassVisor)
			label_c = right_c ? dbf_pkg::LabelRightVisor : dbf_pkg::LabelLeftVisor;
		else
			label_c = cls_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < dbf_pkg::NumParams; k++)
				par_q[k] <= '0;
			for (int k = 0; k < dbf_pkg::RectDepth; k++)
				rect_q[k] <= '0;
			colsc_q <= '0;
			rowsc_q <= '0;
			split_q <= '0;
			keep_q  <= 1'b0;
		end else begin
			colsc_q <= $signed(par_q[dbf_pkg::ParCols]) *
				$signed({1'b0, par_q[dbf_pkg::ParColScale][15:0]});
			rowsc_q <= $signed(par_q[dbf_pkg::ParRows]) *
				$signed({1'b0, par_q[dbf_pkg::ParRowScale][15:0]});
			if (cfg_valid)
				split_q <= split_column;
			if (cmd.load) begin
				if (param_index < 6'(dbf_pkg::NumParams))
					par_q[param_index[dbf_pkg::ParAw-1:0]] <= param_value;
				else if (param_index < 6'(dbf_pkg::SetDepth))
					rect_q[wr_off[dbf_pkg::RectAw-1:0]] <= param_value;
			end
			if (cmd.check)
				keep_q <= keep_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cls_q     <= box_class;
			score_q   <= box_score;
			norm_q[0] <= box_left;
			norm_q[1] <= box_top;
			norm_q[2] <= box_right;
			norm_q[3] <= box_bottom;
			pre_ok_q  <= (box_class < 4'(dbf_pkg::NumClasses)) &&
				(box_score > dbf_pkg::score_floor(box_class));
		end
		if (cmd.mul)
			edge_q[cmd.edge_sel] <= edge_s;
		if (cmd.check) begin
			label_q <= label_c;
			ox_q    <= dbf_pkg::sat16(rx);
			oy_q    <= dbf_pkg::sat16(ry);
			ow_q    <= dbf_pkg::sat16(rw);
			oh_q    <= dbf_pkg::sat16(rh);
			conf_q  <= score_q;
		end
		if (cmd.emit) begin
			out_x      <= ox_q;
			out_y      <= oy_q;
			out_width  <= ow_q;
			out_height <= oh_q;
			label      <= label_q;
			confidence <= conf_q;
		end
	end

	assign status.keep = keep_q;

endmodule

// File: rtl/detection_box_filter.sv
// Top level of the detection box filter.
// Usage:
// Input channel (in_valid/in_stall) carries load items (action 0) that write one
// image parameter or per-class rectangle value, and box items (action 1) with class, score and corners.
// The split_column register is written on cfg_valid/cfg_ready (always ready).
// The user must write it only while the block is idle; the block does not enforce this.
// A load item is written directly and leaves the block idle. A box item runs
// through the shared edge multiplier (left, top, right, bottom), then a check
// state and an output state; no new item is taken until it is back in idle.
// A kept box appears on the output channel (out_valid/out_stall) in the cycle
// after the output state; rejected boxes give nothing.
// While the receiver stalls, the result holds and no new item is taken until
// the output register is free.
// Reset clears all image parameters and split_column to zero and empties the
// output register.
module detection_box_filter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic [5:0]         param_index,
	input  logic signed [19:0] param_value,
	input  logic [3:0]         box_class,
	input  logic [16:0]        box_score,
	input  logic [16:0]        box_left,
	input  logic [16:0]        box_top,
	input  logic [16:0]        box_right,
	input  logic [16:0]        box_bottom,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [11:0]        split_column,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_width,
	output logic signed [15:0] out_height,
	output logic [3:0]         label,
	output logic [16:0]        confidence
);

	dbf_pkg::cmd_t    cmd;
	dbf_pkg::status_t status;

	dbf_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .action, .in_stall,
		.out_valid, .out_stall, .status, .cmd
	);

	dbf_dp u_dp (
		.clk, .arst_n, .cmd, .status, .cfg_valid, .cfg_ready, .split_column,
		.param_index, .param_value, .box_class, .box_score, .box_left, .box_top,
		.box_right, .box_bottom, .out_x, .out_y, .out_width, .out_height,
		.label, .confidence
	);

endmodule

// File: verif/tb_detection_box_filter.sv
// Testbench for detection_box_filter: random and directed items checked against a predictor.
`timescale 1ns / 100ps

module tb_detection_box_filter;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] w;
		logic signed [15:0] h;
		logic [3:0]         lbl;
		logic [16:0]        conf;
	} kept_box_t;

	class box_scoreboard;
		logic [19:0] settings [dbf_pkg::SetDepth];
		logic [11:0] split_col;
		kept_box_t   pending [$];
		int          errors;

		function new();
			foreach (settings[k])
				settings[k] = '0;
			split_col = '0;
			errors = 0;
		endfunction

		function longint sx20(logic [19:0] r);
			return longint'($signed(r));
		endfunction

		function longint q28_to_int(longint v);
			return v >= 0 ? (v >>> 28) : -((-v) >>> 28);
		endfunction

		function logic [15:0] clamp16(longint v);
			if (v > 32767)
				return 16'h7fff;
			if (v < -32768)
				return 16'h8000;
			return v[15:0];
		endfunction

		function longint lim_floor(logic [3:0] c);
			case (c)
				4'd1: return 23592;
				4'd2, 4'd3, 4'd5, 4'd6: return 39321;
				4'd4: return 32768;
				default: return 65536;
			endcase
		endfunction

		function void note_item(logic act, logic [5:0] idx, logic [19:0] val, logic [3:0] cls,
				logic [16:0] sc, logic [16:0] l, logic [16:0] t, logic [16:0] r,
				logic [16:0] b);
			longint cols, rows, cx, cy, wt, wb, cs, rs, x0, y0, x1e, y1e, hh;
			longint rx, ry, rw, rh, fx, fy, fw, fh, ax, ay, bx, by, area;
			int base;
			kept_box_t k;
			if (act == dbf_pkg::ActLoad) begin
				if (idx < dbf_pkg::SetDepth)
					settings[idx] = val;
				return;
			end
			if (cls >= dbf_pkg::NumClasses)
				return;
			if (longint'(sc) <= lim_floor(cls))
				return;
			cols = sx20(settings[dbf_pkg::ParCols]);
			rows = sx20(settings[dbf_pkg::ParRows]);
			cx = sx20(settings[dbf_pkg::ParCropX]);
			cy = sx20(settings[dbf_pkg::ParCropY]);
			wt = sx20(settings[dbf_pkg::ParWinTop]);
			wb = sx20(settings[dbf_pkg::ParWinBot]);
			cs = longint'(settings[dbf_pkg::ParColScale][15:0]);
			rs = longint'(settings[dbf_pkg::ParRowScale][15:0]);
			x0 = longint'(l) * cols * cs + cx * 64'sd16777216;
			y0 = longint'(t) * rows * rs + cy * 64'sd16777216;
			x1e = longint'(r) * cols * cs + cx * 64'sd16777216;
			y1e = longint'(b) * rows * rs + cy * 64'sd16777216;
			hh = y1e - y0;
			if (hh <= 0)
				return;
			if ((wt * 64'sd16777216 - y0) * 10 > 3 * hh)
				return;
			if ((y1e - wb * 64'sd16777216) * 10 > 3 * hh)
				return;
			rx = q28_to_int(x0);
			ry = q28_to_int(y0);
			rw = q28_to_int(x1e - x0);
			rh = q28_to_int(hh);
			base = dbf_pkg::NumParams + 4 * cls;
			fx = sx20(settings[base]);
			fy = sx20(settings[base + 1]);
			fw = sx20(settings[base + 2]);
			fh = sx20(settings[base + 3]);
			ax = rx > fx ? rx : fx;
			ay = ry > fy ? ry : fy;
			bx = (rx + rw) < (fx + fw) ? rx + rw : fx + fw;
			by = (ry + rh) < (fy + fh) ? ry + rh : fy + fh;
			area = (bx > ax && by > ay) ? (bx - ax) * (by - ay) : 0;
			if (area > 1)
				return;
			if (cls == dbf_pkg::ClassBelt || cls == dbf_pkg::ClassVisor) begin
				if (2 * x0 < longint'(split_col) * cs * 65536)
					k.lbl = cls == dbf_pkg::ClassBelt ? dbf_pkg::LabelRightBelt
						: dbf_pkg::LabelRightVisor;
				else
					k.lbl = cls == dbf_pkg::ClassBelt ? dbf_pkg::LabelLeftBelt
						: dbf_pkg::LabelLeftVisor;
			end else begin
				k.lbl = cls;
			end
			k.x = clamp16(rx);
			k.y = clamp16(ry);
			k.w = clamp16(rw);
			k.h = clamp16(rh);
			k.conf = sc;
			pending.insert(pending.size(), k);
		endfunction

		function void check_result(kept_box_t got);
			kept_box_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected box x=%0d y=%0d", $time, got.x, got.y);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.x !== e.x || got.y !== e.y || got.w !== e.w || got.h !== e.h
					|| got.lbl !== e.lbl || got.conf !== e.conf) begin
				$display("%0t: expected x=%0d y=%0d w=%0d h=%0d lbl=%0d conf=%0d", $time,
					e.x, e.y, e.w, e.h, e.lbl, e.conf);
				$display("%0t: actual   x=%0d y=%0d w=%0d h=%0d lbl=%0d conf=%0d", $time,
					got.x, got.y, got.w, got.h, got.lbl, got.conf);
				errors++;
			end
		endfunction
	endclass

	localparam int WatchLimit = 20000;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_stall;
	logic               action = 0;
	logic [5:0]         param_index = 0;
	logic signed [19:0] param_value = 0;
	logic [3:0]         box_class = 0;
	logic [16:0]        box_score = 0, box_left = 0, box_top = 0, box_right = 0, box_bottom = 0;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic [11:0]        split_column = 0;
	logic               out_valid;
	logic               out_stall = 0;
	logic signed [15:0] out_x, out_y, out_width, out_height;
	logic [3:0]         label;
	logic [16:0]        confidence;

	box_scoreboard sb = new();
	int  idle_cycles = 0;
	bit  rx_on = 1;

	detection_box_filter dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WatchLimit) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// result side: check and random stall
	always @(posedge clk) begin
		kept_box_t g;
		if (out_valid && !out_stall) begin
			g.x = out_x;
			g.y = out_y;
			g.w = out_width;
			g.h = out_height;
			g.lbl = label;
			g.conf = confidence;
			sb.check_result(g);
		end
		if (rx_on)
			out_stall <= ($urandom_range(0, 99) < 30) ? 1'b1 : 1'b0;
		else
			out_stall <= 1'b0;
		if ($urandom_range(0, 99) < 2)
			rx_on <= !rx_on;
	end

	task automatic send(logic act, logic [5:0] idx, logic [19:0] val, logic [3:0] cls,
			logic [16:0] sc, logic [16:0] l, logic [16:0] t, logic [16:0] r, logic [16:0] b);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		action <= act;
		param_index <= idx;
		param_value <= val;
		box_class <= cls;
		box_score <= sc;
		box_left <= l;
		box_top <= t;
		box_right <= r;
		box_bottom <= b;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_item(act, idx, val, cls, sc, l, t, r, b);
	endtask

	task automatic load(int idx, int val);
		send(dbf_pkg::ActLoad, 6'(idx), 20'(val), 4'($urandom), 17'($urandom), 17'($urandom),
			17'($urandom), 17'($urandom), 17'($urandom));
	endtask

	task automatic box(int cls, int sc, int l, int t, int r, int b);
		send(dbf_pkg::ActBox, 6'($urandom), 20'($urandom), 4'(cls), 17'(sc), 17'(l), 17'(t),
			17'(r), 17'(b));
	endtask

	task automatic write_split(int v);
		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		cfg_valid <= 1;
		split_column <= 12'(v);
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.split_col = 12'(v);
		cfg_valid <= 0;
	endtask

	// random image settings and per-class rects; wild draws unbounded cols, rows, crops and scales
	task automatic load_image(bit wild);
		int k;
		load(dbf_pkg::ParCols, wild ? $urandom : $urandom_range(1, 2000));
		load(dbf_pkg::ParRows, wild ? $urandom : $urandom_range(1, 2000));
		load(dbf_pkg::ParCropX, wild ? $urandom : $urandom_range(0, 800) - 400);
		load(dbf_pkg::ParCropY, wild ? $urandom : $urandom_range(0, 800) - 400);
		load(dbf_pkg::ParWinTop, $urandom_range(0, 2000) - 1000);
		load(dbf_pkg::ParWinBot, $urandom_range(0, 40000));
		load(dbf_pkg::ParColScale,
			wild ? $urandom : $urandom_range(2048, 8192) | ($urandom_range(0, 15) << 16));
		load(dbf_pkg::ParRowScale, wild ? $urandom : $urandom_range(2048, 8192));
		for (k = dbf_pkg::NumParams; k < dbf_pkg::SetDepth; k += 4) begin
			load(k, $urandom_range(0, 1200) - 100);
			load(k + 1, $urandom_range(0, 1200) - 100);
			load(k + 2, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300) - 20);
			load(k + 3, $urandom_range(0, 300) - 20);
		end
	endtask

	task automatic rand_box();
		int l, t, r, b, sc;
		int cls;
		cls = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 6);
		sc = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(20000, 65536);
		l = $urandom_range(0, 65536);
		t = $urandom_range(0, 60000);
		r = $urandom_range(0, 65536);
		b = $urandom_range(0, 7) == 0 ? $urandom_range(0, 65536) : t + $urandom_range(1, 5536);
		if ($urandom_range(0, 19) == 0) begin
			l = $urandom;
			t = $urandom;
			r = $urandom;
			b = $urandom;
		end
		box(cls, sc, l, t, r, b);
	endtask

	initial begin
		int n;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// default state, thresholds and extremes
		box(0, 131071, 0, 0, 65536, 65536);
		load(dbf_pkg::ParCols, 640);
		load(dbf_pkg::ParRows, 480);
		load(dbf_pkg::ParWinBot, 480 * 16);
		load(dbf_pkg::ParColScale, 4096);
		load(dbf_pkg::ParRowScale, 4096);
		load(63, 524287);
		load(36, 524288);
		box(1, 23592, 0, 0, 30000, 30000);
		box(1, 23593, 0, 0, 30000, 30000);
		box(4, 32769, 1000, 1000, 20000, 20000);
		box(4, 65536, 60000, 1000, 65000, 20000);
		box(2, 39322, 1000, 1000, 20000, 20000);
		box(2, 39322, 60000, 1000, 65000, 20000);
		box(3, 65536, 0, 20000, 65536, 20000);
		box(5, 65536, 0, 0, 65536, 65536);
		box(6, 65536, 100, 0, 200, 65536);
		box(7, 65536, 0, 0, 100, 100);
		box(15, 131071, 0, 0, 100, 100);
		box(0, 65536, 0, 0, 100, 100);
		load(dbf_pkg::NumParams + 4 * 5, 0);
		load(dbf_pkg::NumParams + 1 + 4 * 5, 0);
		load(dbf_pkg::NumParams + 2 + 4 * 5, 100);
		load(dbf_pkg::NumParams + 3 + 4 * 5, 100);
		box(5, 65536, 0, 0, 65536, 65536);
		write_split(4095);
		box(4, 65536, 1000, 1000, 20000, 20000);
		for (n = 0; n < 1700; ) begin
			if ((n % 150) == 0) begin
				write_split($urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 4095 : 0)
					: $urandom);
				load_image($urandom_range(0, 9) == 0);
				n += 36;
			end
			if ($urandom_range(0, 19) == 0)
				load($urandom, $urandom);
			else
				rand_box();
			n++;
		end
		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
